@@ rtl/fsgs_pkg.sv @@
// Shared types and constants for the falling-sand grid step unit.
// Depends on nothing; fsgs_nbr_unit and the top level in rtl/ import it.
`default_nettype none

package fsgs_pkg;

  // Default grid size, handed to the top-level parameters.
  localparam int GRID_COLUMNS_DEF = 64;
  localparam int GRID_ROWS_DEF    = 64;

  // One stored cell: bit 0 says a grain is there, bit 1 says it is resting.
  localparam int CELL_W   = 2;
  localparam int OCC_BIT  = 0;
  localparam int REST_BIT = 1;

  typedef logic [CELL_W-1:0] cell_t;

  localparam cell_t CELL_EMPTY     = 2'b00;
  localparam cell_t CELL_GRAIN     = 2'b01;
  localparam cell_t CELL_REST_MASK = 2'b10;

  // Item modes.
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Which neighbour of the current cell the address unit points at.
  typedef enum logic [3:0] {
    NBR_HERE,
    NBR_BELOW,
    NBR_RIGHT,
    NBR_BELOW_RIGHT,
    NBR_LEFT,
    NBR_BELOW_LEFT,
    NBR_UP_LEFT,
    NBR_UP,
    NBR_UP_RIGHT
  } nbr_sel_t;

  // Which neighbours exist for the current cell.
  typedef struct packed {
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
  } nbr_flags_t;

  typedef struct packed {
    logic occupied;
    logic resting;
    logic added;
    logic moved;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ITEM_RD,
    ST_ITEM_EVAL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_BELOW,
    ST_RIGHT,
    ST_BELOW_RIGHT,
    ST_LEFT,
    ST_BELOW_LEFT,
    ST_MOVE_HERE,
    ST_REL_RD,
    ST_REL_CHK,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/fsgs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the cell grid of the falling-sand grid step unit.
`default_nettype none

module fsgs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/fsgs_nbr_unit.sv @@
// Shared neighbour address unit: turns a grid position and a neighbour
// select into a RAM address, and reports which neighbours exist. Uses fsgs_pkg.
`default_nettype none

module fsgs_nbr_unit #(
  parameter int GRID_COLUMNS = fsgs_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = fsgs_pkg::GRID_ROWS_DEF,
  localparam int RW = $clog2(GRID_ROWS),
  localparam int CW = $clog2(GRID_COLUMNS)
) (
  input  logic [RW-1:0]        row,
  input  logic [CW-1:0]        col,
  input  fsgs_pkg::nbr_sel_t   sel,
  output logic [RW+CW-1:0]     addr,
  output fsgs_pkg::nbr_flags_t flags
);
  import fsgs_pkg::*;

  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLUMNS - 1);

  logic [RW-1:0] row_up, row_dn, row_sel;
  logic [CW-1:0] col_l, col_r, col_sel;

  assign row_up = row - RW'(1);
  assign row_dn = row + RW'(1);
  assign col_l  = col - CW'(1);
  assign col_r  = col + CW'(1);

  // Existence depends on the position only, never on the select.
  assign flags.has_up    = (row != '0);
  assign flags.has_down  = (row != ROW_LAST);
  assign flags.has_left  = (col != '0);
  assign flags.has_right = (col != COL_LAST);

  always_comb begin
    row_sel = row;
    col_sel = col;
    case (sel)
      NBR_HERE: begin
        row_sel = row;
        col_sel = col;
      end
      NBR_BELOW: begin
        row_sel = row_dn;
      end
      NBR_RIGHT: begin
        col_sel = col_r;
      end
      NBR_BELOW_RIGHT: begin
        row_sel = row_dn;
        col_sel = col_r;
      end
      NBR_LEFT: begin
        col_sel = col_l;
      end
      NBR_BELOW_LEFT: begin
        row_sel = row_dn;
        col_sel = col_l;
      end
      NBR_UP_LEFT: begin
        row_sel = row_up;
        col_sel = col_l;
      end
      NBR_UP: begin
        row_sel = row_up;
      end
      NBR_UP_RIGHT: begin
        row_sel = row_up;
        col_sel = col_r;
      end
      default: begin
        row_sel = row;
        col_sel = col;
      end
    endcase
  end

  assign addr = {row_sel, col_sel};

endmodule

`default_nettype wire

@@ rtl/falling_sand_grid_step_unit.sv @@
// Top level of the falling-sand grid step unit: sequencer, cell RAM and
// shared neighbour address unit. Uses fsgs_pkg, fsgs_ram and fsgs_nbr_unit.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+---------------------------------
//   item     | item_valid / item_ready    | mode, cell_column, cell_row
//   result   | result_valid / result_ready| cell_occupied, cell_resting,
//            |                            | grain_added, any_moved
//
// After reset the unit sweeps the cell RAM, one address per cycle, over all
// 2**(clog2(GRID_ROWS) + clog2(GRID_COLUMNS)) addresses (4096 at 64 x 64);
// item_ready stays low during that sweep.
// Add and read items pass through ST_ITEM_RD and ST_ITEM_EVAL to ST_RESULT,
// which loads the result register; an unused-mode item goes straight to
// ST_RESULT. A tick pass walks every cell through the single RAM read port:
// an empty or resting cell is skipped as soon as it is read; a grain settles
// or moves after its below, side and diagonal checks, and a move is followed
// by the release of the row above.
// The unit takes one transaction at a time; a finished result waits in the
// output register while the next transaction is already being worked on, and
// that next result is held back until the waiting one has been taken.
`default_nettype none

module falling_sand_grid_step_unit #(
  parameter int GRID_COLUMNS = fsgs_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = fsgs_pkg::GRID_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] mode,
  input  logic [5:0] cell_column,
  input  logic [5:0] cell_row,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       cell_occupied,
  output logic       cell_resting,
  output logic       grain_added,
  output logic       any_moved
);
  import fsgs_pkg::*;

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLUMNS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLUMNS - 1);

  // Sequencer state and working registers.
  state_t        state, state_next;
  logic [RW-1:0] scan_row, scan_row_next;
  logic [CW-1:0] scan_col, scan_col_next;
  cell_t         cell_v, cell_v_next;
  nbr_sel_t      rel_sel, rel_sel_next;
  logic [1:0]    item_mode, item_mode_next;
  logic          item_inside, item_inside_next;
  result_t       pend, pend_next;
  logic [AW-1:0] clr_addr;

  // Position that follows the current one in scan order.
  logic [RW-1:0] adv_row;
  logic [CW-1:0] adv_col;
  logic          adv_done;

  // Address unit and RAM hookup.
  logic          use_adv;
  logic [RW-1:0] base_row;
  logic [CW-1:0] base_col;
  nbr_sel_t      sel;
  logic [AW-1:0] nbr_addr;
  nbr_flags_t    flags;
  logic          wr_en;
  logic          wr_clear;
  cell_t         wr_data;
  logic [AW-1:0] wr_addr;
  cell_t         rd_data;

  logic in_inside;
  logic load_result;
  logic try_left, block, advance, rel_step, rel_ok;

  assign item_ready = (state == ST_IDLE);

  assign in_inside = (32'(cell_column) < GRID_COLUMNS) && (32'(cell_row) < GRID_ROWS);

  // Scan order: rows from bottom to top, each row from left to right.
  always_comb begin
    adv_done = (scan_row == '0) && (scan_col == COL_LAST);
    if (scan_col == COL_LAST) begin
      adv_col = '0;
      adv_row = scan_row - RW'(1);
    end else begin
      adv_col = scan_col + CW'(1);
      adv_row = scan_row;
    end
  end

  // A cell that is empty or resting needs no work, so the scan moves on and
  // reads the next cell in the same cycle. This depends on the read data
  // only, which keeps the address path free of loops.
  assign use_adv  = (state == ST_SCAN_CHK) &&
                    (!rd_data[OCC_BIT] || rd_data[REST_BIT]);
  assign base_row = use_adv ? adv_row : scan_row;
  assign base_col = use_adv ? adv_col : scan_col;

  fsgs_nbr_unit #(
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_ROWS   (GRID_ROWS)
  ) u_nbr (
    .row  (base_row),
    .col  (base_col),
    .sel  (sel),
    .addr (nbr_addr),
    .flags(flags)
  );

  assign wr_addr = wr_clear ? clr_addr : nbr_addr;

  // The read port always follows the address unit; each state consumes the
  // data of the address issued in the cycle before.
  fsgs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(nbr_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    scan_row_next    = scan_row;
    scan_col_next    = scan_col;
    cell_v_next      = cell_v;
    rel_sel_next     = rel_sel;
    item_mode_next   = item_mode;
    item_inside_next = item_inside;
    pend_next        = pend;
    sel              = NBR_HERE;
    wr_en            = 1'b0;
    wr_clear         = 1'b0;
    wr_data          = CELL_EMPTY;
    load_result      = 1'b0;
    try_left         = 1'b0;
    block            = 1'b0;
    advance          = 1'b0;
    rel_step         = 1'b0;
    rel_ok           = 1'b0;

    case (state)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_clear = 1'b1;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (item_valid) begin
          pend_next        = '0;
          item_mode_next   = mode;
          item_inside_next = in_inside;
          case (mode)
            MODE_TICK: begin
              scan_row_next = ROW_LAST;
              scan_col_next = '0;
              state_next    = ST_SCAN_RD;
            end
            MODE_ADD, MODE_READ: begin
              scan_row_next = RW'(cell_row);
              scan_col_next = CW'(cell_column);
              state_next    = ST_ITEM_RD;
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end

      ST_ITEM_RD: begin
        state_next = ST_ITEM_EVAL;
      end

      ST_ITEM_EVAL: begin
        if (item_mode == MODE_ADD) begin
          if (item_inside && !rd_data[OCC_BIT]) begin
            wr_en           = 1'b1;
            wr_data         = CELL_GRAIN;
            pend_next.added = 1'b1;
          end
        end else begin
          pend_next.occupied = item_inside && rd_data[OCC_BIT];
          pend_next.resting  = item_inside && rd_data[OCC_BIT] && rd_data[REST_BIT];
        end
        state_next = ST_RESULT;
      end

      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (use_adv) begin
          if (adv_done) begin
            state_next = ST_RESULT;
          end else begin
            scan_row_next = adv_row;
            scan_col_next = adv_col;
          end
        end else if (!flags.has_down) begin
          wr_en   = 1'b1;
          wr_data = rd_data | CELL_REST_MASK;
          advance = 1'b1;
        end else begin
          cell_v_next = rd_data;
          sel         = NBR_BELOW;
          state_next  = ST_BELOW;
        end
      end

      ST_BELOW: begin
        if (!rd_data[OCC_BIT]) begin
          sel        = NBR_BELOW;
          wr_en      = 1'b1;
          wr_data    = cell_v;
          state_next = ST_MOVE_HERE;
        end else if (flags.has_right) begin
          sel        = NBR_RIGHT;
          state_next = ST_RIGHT;
        end else begin
          try_left = 1'b1;
        end
      end

      ST_RIGHT: begin
        if (!rd_data[OCC_BIT]) begin
          sel        = NBR_BELOW_RIGHT;
          state_next = ST_BELOW_RIGHT;
        end else begin
          try_left = 1'b1;
        end
      end

      ST_BELOW_RIGHT: begin
        if (!rd_data[OCC_BIT]) begin
          sel        = NBR_RIGHT;
          wr_en      = 1'b1;
          wr_data    = cell_v;
          state_next = ST_MOVE_HERE;
        end else begin
          try_left = 1'b1;
        end
      end

      ST_LEFT: begin
        if (!rd_data[OCC_BIT]) begin
          sel        = NBR_BELOW_LEFT;
          state_next = ST_BELOW_LEFT;
        end else begin
          block = 1'b1;
        end
      end

      ST_BELOW_LEFT: begin
        if (!rd_data[OCC_BIT]) begin
          sel        = NBR_LEFT;
          wr_en      = 1'b1;
          wr_data    = cell_v;
          state_next = ST_MOVE_HERE;
        end else begin
          block = 1'b1;
        end
      end

      ST_MOVE_HERE: begin
        wr_en           = 1'b1;
        wr_data         = CELL_EMPTY;
        pend_next.moved = 1'b1;
        rel_sel_next    = NBR_UP_LEFT;
        state_next      = ST_REL_RD;
      end

      ST_REL_RD: begin
        sel = rel_sel;
        if (rel_sel == NBR_UP_LEFT) begin
          rel_ok = flags.has_up && flags.has_left;
        end else if (rel_sel == NBR_UP_RIGHT) begin
          rel_ok = flags.has_up && flags.has_right;
        end else begin
          rel_ok = flags.has_up;
        end
        if (rel_ok) begin
          state_next = ST_REL_CHK;
        end else begin
          rel_step = 1'b1;
        end
      end

      ST_REL_CHK: begin
        sel = rel_sel;
        if (rd_data[OCC_BIT]) begin
          wr_en   = 1'b1;
          wr_data = CELL_GRAIN;
        end
        rel_step = 1'b1;
      end

      ST_RESULT: begin
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Right step failed or was not possible: try the step to the left.
    if (try_left) begin
      if (flags.has_left) begin
        sel        = NBR_LEFT;
        state_next = ST_LEFT;
      end else begin
        block = 1'b1;
      end
    end

    // No move is possible, so the grain settles where it is.
    if (block) begin
      sel     = NBR_HERE;
      wr_en   = 1'b1;
      wr_data = cell_v | CELL_REST_MASK;
      advance = 1'b1;
    end

    // Release walks the three cells above the old position in turn.
    if (rel_step) begin
      if (rel_sel == NBR_UP_RIGHT) begin
        advance = 1'b1;
      end else if (rel_sel == NBR_UP_LEFT) begin
        rel_sel_next = NBR_UP;
        state_next   = ST_REL_RD;
      end else begin
        rel_sel_next = NBR_UP_RIGHT;
        state_next   = ST_REL_RD;
      end
    end

    if (advance) begin
      if (adv_done) begin
        state_next = ST_RESULT;
      end else begin
        scan_row_next = adv_row;
        scan_col_next = adv_col;
        state_next    = ST_SCAN_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_row    <= scan_row_next;
    scan_col    <= scan_col_next;
    cell_v      <= cell_v_next;
    rel_sel     <= rel_sel_next;
    item_mode   <= item_mode_next;
    item_inside <= item_inside_next;
    pend        <= pend_next;
    if (load_result) begin
      cell_occupied <= pend.occupied;
      cell_resting  <= pend.resting;
      grain_added   <= pend.added;
      any_moved     <= pend.moved;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fsgs_checker.sv @@
// Port-level checks for the falling-sand grid step unit, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module fsgs_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic result_valid,
  input logic result_ready,
  input logic cell_occupied,
  input logic cell_resting,
  input logic grain_added,
  input logic any_moved
);

  logic       in_acc, out_acc;
  logic [1:0] owed;

  assign in_acc  = item_valid && item_ready;
  assign out_acc = result_valid && result_ready;

  // Transactions accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= 2'd0;
    end else if (in_acc && !out_acc) begin
      owed <= owed + 2'd1;
    end else if (out_acc && !in_acc) begin
      owed <= owed - 2'd1;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !item_ready)
    else $error("item_ready stayed high after an accepted transaction");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> (!item_ready && !result_valid))
    else $error("unit not quiet after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (owed != 2'd0))
    else $error("result offered with no transaction outstanding");

  a_one_mode_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (($countones({cell_occupied, grain_added, any_moved}) <= 1) &&
                      (!cell_resting || cell_occupied)))
    else $error("result mixes fields of different modes");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable({cell_occupied, cell_resting, grain_added, any_moved})))
    else $error("stalled result changed or dropped");

endmodule

bind falling_sand_grid_step_unit fsgs_checker u_fsgs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .cell_occupied(cell_occupied),
  .cell_resting (cell_resting),
  .grain_added  (grain_added),
  .any_moved    (any_moved)
);

`default_nettype wire

@@ verif/falling_sand_grid_step_unit_test.sv @@
// Self-checking testbench for falling_sand_grid_step_unit: add, read, tick and unused-mode
// transactions are predicted by a grid model kept in the bench and compared field by field.
// Depends on fsgs_pkg and the falling_sand_grid_step_unit RTL.
`timescale 1ns / 100ps

module falling_sand_grid_step_unit_test;
  import fsgs_pkg::*;

  localparam int GRID_COLS = GRID_COLUMNS_DEF;
  localparam int GRID_ROWS = GRID_ROWS_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // The sender never inserts a longer idle gap than this before a transaction.
  localparam int MAX_SEND_GAP = 24;
  // Cycles allowed for the block to settle after the last result.
  localparam int DRAIN_CYCLES = 32;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [1:0] mode = MODE_TICK;
  logic [5:0] cell_column = '0;
  logic [5:0] cell_row = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic       cell_occupied;
  logic       cell_resting;
  logic       grain_added;
  logic       any_moved;

  falling_sand_grid_step_unit #(
    .GRID_COLUMNS(GRID_COLS),
    .GRID_ROWS   (GRID_ROWS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .mode         (mode),
    .cell_column  (cell_column),
    .cell_row     (cell_row),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cell_occupied(cell_occupied),
    .cell_resting (cell_resting),
    .grain_added  (grain_added),
    .any_moved    (any_moved)
  );

  // The bench's own copy of the grid, indexed [row][column], row 0 at the top.
  cell_t sand_grid [0:GRID_ROWS-1][0:GRID_COLS-1];

  // Results predicted at acceptance time, oldest first.
  result_t pending_results [$];

  // Idle controls, changed from phase to phase. Values are percent per cycle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int error_count = 0;
  int results_checked = 0;
  int tick_count = 0;
  int moving_ticks = 0;
  int add_count = 0;
  int placed_count = 0;
  int read_count = 0;
  int unused_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest correct run here is roughly 130 transactions, some of them
  // tick passes over the whole grid, plus the clearing sweep; the limit below is
  // several times that.
  initial begin
    #20_000_000;
    $display("Timeout: %0d results still outstanding", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  // The block comes out of reset with every cell empty and not resting.
  function automatic void clear_grid();
    int r;
    int c;
    for (r = 0; r < GRID_ROWS; r++) begin
      for (c = 0; c < GRID_COLS; c++) begin
        sand_grid[r][c] = CELL_EMPTY;
      end
    end
  endfunction

  function automatic bit is_occupied(int row, int col);
    return sand_grid[row][col][OCC_BIT];
  endfunction

  // After a grain leaves a cell, the grains in the row above it (same column and
  // both neighbours) lose their resting mark so they get another look this pass.
  function automatic void wake_row_above(int row, int col);
    int c;
    if (row == 0) return;
    for (c = col - 1; c <= col + 1; c++) begin
      if (c >= 0 && c < GRID_COLS && is_occupied(row - 1, c)) begin
        sand_grid[row - 1][c][REST_BIT] = 1'b0;
      end
    end
  endfunction

  // One in-place pass, bottom row first, left to right within a row. A grain
  // that steps right lands in a cell that the scan has not reached yet, so it
  // gets a second chance to move in the same pass.
  function automatic bit sweep_grid();
    int row;
    int col;
    int dest_row;
    int dest_col;
    cell_t grain;
    bit moved;
    bit any = 1'b0;
    for (row = GRID_ROWS - 1; row >= 0; row--) begin
      for (col = 0; col < GRID_COLS; col++) begin
        grain = sand_grid[row][col];
        if (!grain[OCC_BIT] || grain[REST_BIT]) continue;
        if (row == GRID_ROWS - 1) begin
          sand_grid[row][col][REST_BIT] = 1'b1;
          continue;
        end
        moved = 1'b1;
        dest_row = row;
        dest_col = col;
        if (!is_occupied(row + 1, col)) begin
          dest_row = row + 1;
        end else if (col + 1 < GRID_COLS && !is_occupied(row, col + 1) &&
                     !is_occupied(row + 1, col + 1)) begin
          dest_col = col + 1;
        end else if (col >= 1 && !is_occupied(row, col - 1) &&
                     !is_occupied(row + 1, col - 1)) begin
          dest_col = col - 1;
        end else begin
          moved = 1'b0;
        end
        if (moved) begin
          sand_grid[dest_row][dest_col] = grain;
          sand_grid[row][col] = CELL_EMPTY;
          any = 1'b1;
          wake_row_above(row, col);
        end else begin
          sand_grid[row][col][REST_BIT] = 1'b1;
        end
      end
    end
    return any;
  endfunction

  // Applies one accepted transaction to the grid copy and returns what the
  // block must answer. Fields that do not belong to the mode stay zero.
  function automatic result_t predict_cell_result(logic [1:0] m, logic [5:0] col,
                                                  logic [5:0] row);
    result_t res;
    bit in_grid;
    res = '0;
    in_grid = (int'(col) < GRID_COLS) && (int'(row) < GRID_ROWS);
    case (m)
      MODE_TICK: begin
        res.moved = sweep_grid();
      end
      MODE_ADD: begin
        if (in_grid && !is_occupied(row, col)) begin
          sand_grid[row][col] = CELL_GRAIN;
          res.added = 1'b1;
        end
      end
      MODE_READ: begin
        if (in_grid) begin
          res.occupied = sand_grid[row][col][OCC_BIT];
          res.resting  = sand_grid[row][col][OCC_BIT] & sand_grid[row][col][REST_BIT];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Sends one transaction and returns at the edge where it was accepted. Valid is
  // left high so that a following transaction can go out back to back; the gap
  // before the next one (if any) lowers it at that same edge.
  task automatic send_item(logic [1:0] m, logic [5:0] col, logic [5:0] row);
    int gap;
    result_t want;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    mode        <= m;
    cell_column <= col;
    cell_row    <= row;
    do @(posedge clk); while (!item_ready);
    want = predict_cell_result(m, col, row);
    pending_results.push_back(want);
    case (m)
      MODE_TICK: begin
        tick_count++;
        if (want.moved) moving_ticks++;
      end
      MODE_ADD: begin
        add_count++;
        if (want.added) placed_count++;
      end
      MODE_READ: read_count++;
      default: unused_count++;
    endcase
  endtask

  // Holds the sender off until every outstanding result has been checked.
  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The receiver stalls at random; a zero setting keeps ready high throughout.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  result_t got_result;
  result_t want_result;

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      got_result = '{occupied: cell_occupied, resting: cell_resting,
                     added: grain_added, moved: any_moved};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %b arrived with nothing expected", got_result));
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.occupied !== want_result.occupied)
          report_mismatch($sformatf("result %0d cell_occupied got %b expected %b",
                                    results_checked, got_result.occupied,
                                    want_result.occupied));
        if (got_result.resting !== want_result.resting)
          report_mismatch($sformatf("result %0d cell_resting got %b expected %b",
                                    results_checked, got_result.resting,
                                    want_result.resting));
        if (got_result.added !== want_result.added)
          report_mismatch($sformatf("result %0d grain_added got %b expected %b",
                                    results_checked, got_result.added,
                                    want_result.added));
        if (got_result.moved !== want_result.moved)
          report_mismatch($sformatf("result %0d any_moved got %b expected %b",
                                    results_checked, got_result.moved,
                                    want_result.moved));
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A freshly reset grid must read empty at three of its corners.
  task automatic test_empty_after_reset();
    send_item(MODE_READ, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd63, 6'd63);
    send_item(MODE_READ, 6'd63, 6'd0);
  endtask

  // Adds at two corners and one row above the floor, a second add on an occupied cell, and a read back.
  task automatic test_add_and_collision();
    send_item(MODE_ADD, 6'd0, 6'd0);
    send_item(MODE_ADD, 6'd0, 6'd0);
    send_item(MODE_ADD, 6'd63, 6'd63);
    send_item(MODE_ADD, 6'd31, 6'd62);
    send_item(MODE_READ, 6'd0, 6'd0);
  endtask

  // The unused mode must change nothing and answer all zeros.
  task automatic test_unused_mode();
    send_item(MODE_UNUSED, 6'd63, 6'd63);
    send_item(MODE_UNUSED, 6'd0, 6'd0);
  endtask

  // Grains fall one row per pass; a grain on the bottom row settles.
  task automatic test_fall_and_settle();
    send_item(MODE_TICK, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd0, 6'd1);
    send_item(MODE_READ, 6'd63, 6'd63);
    send_item(MODE_READ, 6'd31, 6'd63);
    send_item(MODE_TICK, 6'd63, 6'd63);
  endtask

  // A grain landing on a settled one steps right and is met again so it falls
  // in the same pass; one at the right edge has no right column and steps left.
  task automatic test_side_steps();
    send_item(MODE_ADD, 6'd31, 6'd62);
    send_item(MODE_ADD, 6'd63, 6'd62);
    send_item(MODE_TICK, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd32, 6'd63);
    send_item(MODE_READ, 6'd62, 6'd62);
    send_item(MODE_TICK, 6'd0, 6'd0);
  endtask

  // Three positions in four lie in a narrow band near the floor so that piles form,
  // side steps get blocked and the row-above release fires; the rest lie anywhere.
  // Reads and adds are the most common items, then ticks, then the unused mode.
  task automatic test_random_phase(int send_pct, int stall_pct, int count);
    int n;
    int pick;
    logic [5:0] col;
    logic [5:0] row;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 75) begin
        col = 6'($urandom_range(26, 37));
        row = 6'($urandom_range(54, 63));
      end else begin
        col = 6'($urandom_range(0, 63));
        row = 6'($urandom_range(0, 63));
      end
      if (pick < 20)      send_item(MODE_TICK, col, row);
      else if (pick < 55) send_item(MODE_ADD, col, row);
      else if (pick < 93) send_item(MODE_READ, col, row);
      else                send_item(MODE_UNUSED, col, row);
    end
    // Let every transaction of this phase finish before the next phase starts.
    drain_results();
  endtask

  initial begin
    clear_grid();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_after_reset();
    test_add_and_collision();
    test_unused_mode();
    test_fall_and_settle();
    test_side_steps();
    drain_results();

    test_random_phase(0, 0, 25);
    test_random_phase(53, 0, 25);
    test_random_phase(0, 53, 25);
    test_random_phase(9, 9, 25);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Covered %0d tick passes (%0d with movement), %0d adds (%0d placed),",
             tick_count, moving_ticks, add_count, placed_count);
    $display("%0d reads and %0d unused-mode transactions; %0d results checked, %0d mismatches",
             read_count, unused_count, results_checked, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fsgs_pkg.sv
rtl/fsgs_ram.sv
rtl/fsgs_nbr_unit.sv
rtl/falling_sand_grid_step_unit.sv
rtl/fsgs_checker.sv
verif/falling_sand_grid_step_unit_test.sv
